// ===== hdl/tlps_pkg.sv =====
package tlps_pkg;

   localparam int TableLen = 24;
   localparam logic [31:0] GainQ30 = 32'h26DD3B6A;
   localparam logic [15:0] HeadingReset = 16'd10430;
   localparam logic [14:0] TurnLimitReset = 15'd521;
   localparam logic [15:0] SpeedReset = 16'd600;

   localparam logic CsrTurnLimit = 1'b0;
   localparam logic CsrSpeed = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VEC,
      ST_TURN,
      ST_ROT,
      ST_MUL,
      ST_DONE
   } state_type;

   function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

// ===== hdl/turn_limited_pursuit_step_core.sv =====
// Channel   Direction  Handshake          Payload
// req_      in         req_valid/stall    target_x/y, pursuer_x/y, frame_time
// rsp_      out        rsp_valid/stall    next_x/y, heading_out
// csr_      in         csr_write          csr_index, csr_data
// One item at a time: vectoring over StepCount steps (CORDIC_STEPS capped at
// the table length), a turn state, rotating over StepCount steps, a shift-add
// multiply over the 32 length bits, then a done state; the next request is
// taken once the core is back in idle. Synchronous reset restores heading
// 10430, turn_limit 521, speed 600.
// A result waits in the output registers under rsp_stall while the next
// request runs; only the done cycle holds until the output is free.
module turn_limited_pursuit_step_core #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_pursuer_x,
   input  logic signed [31:0] req_pursuer_y,
   input  logic        [15:0] req_frame_time,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_next_x,
   output logic signed [31:0] rsp_next_y,
   output logic        [15:0] rsp_heading_out,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic        [15:0] csr_data
);

   localparam int StepCount = (CORDIC_STEPS < tlps_pkg::TableLen) ?
                              CORDIC_STEPS : tlps_pkg::TableLen;

   tlps_pkg::state_type state_ff, state_in;

   logic [14:0] turn_limit_ff;
   logic [15:0] speed_ff;
   logic [15:0] heading_ff, heading_in;

   // CORDIC datapath: 35-bit x/y covers the 33-bit difference plus gain growth
   logic signed [34:0] x_ff, x_in, y_ff, y_in;
   logic signed [32:0] z_ff, z_in;
   logic [4:0]         step_ff, step_in;
   logic               flip_ff, flip_in;
   logic               zero_ff, zero_in;

   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic [15:0]        ft_ff, ft_in;

   // bit-serial multiplier: len (32b unsigned) times cos and sin together
   logic [31:0]        len_ff, len_in;
   logic signed [65:0] acc_c_ff, acc_c_in, acc_s_ff, acc_s_in;
   logic signed [31:0] cos_ff, cos_in, sin_ff, sin_in;

   logic signed [31:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [15:0]        hout_ff, hout_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   logic signed [34:0] xs, ys;
   logic [31:0]        atan_val;
   logic [15:0]        brg, diff;
   logic               vec_dir, rot_dir;
   logic signed [16:0] diff_s, mag;
   logic signed [16:0] turn;
   logic signed [32:0] z_rot;
   logic [15:0]        new_head;
   logic signed [33:0] tx_d, ty_d;

   assign req_stall       = (state_ff != tlps_pkg::ST_IDLE);
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_x      = nx_ff;
   assign rsp_next_y      = ny_ff;
   assign rsp_heading_out = hout_ff;

   always_comb begin
      xs       = x_ff >>> step_ff;
      ys       = y_ff >>> step_ff;
      atan_val = tlps_pkg::atan_lookup(step_ff);
      vec_dir  = (y_ff > 0);
      rot_dir  = (z_ff >= 0);
      brg      = zero_ff ? 16'd0 : 16'(({1'b0, z_ff[31:0]} + 33'h8000) >> 16);
      diff     = brg - heading_ff;
      diff_s   = {diff[15], diff};
      mag      = diff_s[16] ? -diff_s : diff_s;
      if (mag < $signed({2'b00, turn_limit_ff})) begin
         turn = diff_s;
      end else if (diff_s[16]) begin
         turn = -$signed({2'b00, turn_limit_ff});
      end else begin
         turn = $signed({2'b00, turn_limit_ff});
      end
      new_head = 16'(heading_ff + 16'(turn));
      z_rot    = $signed({new_head[15], new_head, 16'h0});
      tx_d     = $signed({req_target_x[31], req_target_x}) -
                 $signed({req_pursuer_x[31], req_pursuer_x});
      ty_d     = $signed({req_target_y[31], req_target_y}) -
                 $signed({req_pursuer_y[31], req_pursuer_y});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tlps_pkg::ST_IDLE: if (req_valid && !req_stall) state_in = tlps_pkg::ST_VEC;
         tlps_pkg::ST_VEC:  if (step_ff == 5'(StepCount - 1)) state_in = tlps_pkg::ST_TURN;
         tlps_pkg::ST_TURN: state_in = tlps_pkg::ST_ROT;
         tlps_pkg::ST_ROT:  if (step_ff == 5'(StepCount - 1)) state_in = tlps_pkg::ST_MUL;
         tlps_pkg::ST_MUL:  if (step_ff == 5'd31) state_in = tlps_pkg::ST_DONE;
         tlps_pkg::ST_DONE: if (out_free) state_in = tlps_pkg::ST_IDLE;
         default:           state_in = tlps_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      x_in = x_ff; y_in = y_ff; z_in = z_ff; step_in = step_ff;
      flip_in = flip_ff; zero_in = zero_ff; heading_in = heading_ff;
      px_in = px_ff; py_in = py_ff; ft_in = ft_ff; len_in = len_ff;
      acc_c_in = acc_c_ff; acc_s_in = acc_s_ff; cos_in = cos_ff; sin_in = sin_ff;
      nx_in = nx_ff; ny_in = ny_ff; hout_in = hout_ff; rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      case (state_ff)
         tlps_pkg::ST_IDLE: begin
            if (req_valid && !req_stall) begin
               px_in   = req_pursuer_x;
               py_in   = req_pursuer_y;
               ft_in   = req_frame_time;
               zero_in = (tx_d == 34'sd0) && (ty_d == 34'sd0);
               step_in = 5'd0;
               if (tx_d < 0) begin
                  x_in = 35'(-tx_d); y_in = 35'(-ty_d); z_in = 33'sh080000000;
               end else begin
                  x_in = 35'(tx_d); y_in = 35'(ty_d); z_in = 33'sd0;
               end
            end
         end
         tlps_pkg::ST_VEC: begin
            if (vec_dir) begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + $signed({1'b0, atan_val});
            end else begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - $signed({1'b0, atan_val});
            end
            step_in = step_ff + 5'd1;
         end
         tlps_pkg::ST_TURN: begin
            heading_in = new_head;
            x_in    = 35'($signed(tlps_pkg::GainQ30));
            y_in    = 35'sd0;
            step_in = 5'd0;
            len_in  = speed_ff * ft_ff;
            if (z_rot > 33'sh040000000) begin
               z_in = z_rot - 33'sh080000000; flip_in = 1'b1;
            end else if (z_rot < -33'sh040000000) begin
               z_in = z_rot + 33'sh080000000; flip_in = 1'b1;
            end else begin
               z_in = z_rot; flip_in = 1'b0;
            end
         end
         tlps_pkg::ST_ROT: begin
            if (rot_dir) begin
               x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - $signed({1'b0, atan_val});
            end else begin
               x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + $signed({1'b0, atan_val});
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(StepCount - 1)) begin
               cos_in   = flip_ff ? -32'(x_in) : 32'(x_in);
               sin_in   = flip_ff ? -32'(y_in) : 32'(y_in);
               acc_c_in = 66'sd0;
               acc_s_in = 66'sd0;
               step_in  = 5'd0;
            end
         end
         tlps_pkg::ST_MUL: begin
            // MSB-first shift-add over the length bits
            acc_c_in = (acc_c_ff <<< 1) + (len_ff[31] ? 66'(cos_ff) : 66'sd0);
            acc_s_in = (acc_s_ff <<< 1) + (len_ff[31] ? 66'(sin_ff) : 66'sd0);
            len_in   = len_ff << 1;
            step_in  = step_ff + 5'd1;
         end
         tlps_pkg::ST_DONE: begin
            // load the output only once the previous result has left
            if (out_free) begin
               nx_in = px_ff + 32'((acc_c_ff + 66'sh200000000) >>> 34);
               ny_in = py_ff + 32'((acc_s_ff + 66'sh200000000) >>> 34);
               hout_in = heading_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tlps_pkg::ST_IDLE;
         heading_ff    <= tlps_pkg::HeadingReset;
         turn_limit_ff <= tlps_pkg::TurnLimitReset;
         speed_ff      <= tlps_pkg::SpeedReset;
         rsp_valid_ff  <= 1'b0;
         step_ff       <= 5'd0;
      end else begin
         state_ff     <= state_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         if (csr_write) begin
            if (csr_index == tlps_pkg::CsrTurnLimit) turn_limit_ff <= csr_data[14:0];
            else if (csr_index == tlps_pkg::CsrSpeed) speed_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      flip_ff <= flip_in; zero_ff <= zero_in;
      px_ff <= px_in; py_ff <= py_in; ft_ff <= ft_in; len_ff <= len_in;
      acc_c_ff <= acc_c_in; acc_s_ff <= acc_s_in; cos_ff <= cos_in; sin_ff <= sin_in;
      nx_ff <= nx_in; ny_ff <= ny_in; hout_ff <= hout_in;
   end

`ifndef SYNTH
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tlps_pkg::ST_IDLE) |-> req_stall)
      else $error("request taken while busy");
   a_done_sets_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlps_pkg::ST_DONE) |=> rsp_valid)
      else $error("done without result");
   a_heading_only_turn: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tlps_pkg::ST_TURN) |=> $stable(heading_ff) || $past(reset))
      else $error("heading changed outside turn");
`endif

endmodule
